/* rtl/core/rsit_pkg.sv */
package rsit_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned IdxW = 4;

  typedef logic signed [ValW-1:0] val_t;

  // One plane as queued between the front and the back.
  typedef struct packed {
    val_t             near_d;
    val_t             far_d;
    val_t             offset;
    val_t             slope;
    logic             first;
    logic             last;
    val_t             entry_start;
    val_t             exit_start;
    logic [IdxW-1:0]  plane_start;
  } plane_t;

  typedef struct packed {
    logic             hit;
    val_t             entry_time;
    val_t             exit_time;
    logic [IdxW-1:0]  entry_plane;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FOLD,
    ST_OUT
  } back_state_t;

endpackage

/* rtl/core/rsit_fifo.sv */
module rsit_fifo
  import rsit_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  plane_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output plane_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  plane_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

/* rtl/core/rsit_div.sv */
// Signed restoring divider: (distance - offset) * 2^FRAC_BITS / slope, truncated
// toward zero and saturated to 32 bits. One quotient bit per cycle.
module rsit_div
  import rsit_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  val_t dist_val,
  input  val_t offset,
  input  val_t slope,
  output logic done,
  output val_t quot
);

  localparam int unsigned NW = ValW + 1 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_mag;
  logic [NW-1:0] quo;
  logic [ValW:0] rem;
  logic [ValW:0] den;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          busy;
  logic [ValW:0] diff;
  logic [ValW+1:0] trial;
  logic [ValW:0] rem_sh;
  logic signed [ValW:0] dsub;

  always_comb begin
    dsub    = {dist_val[ValW-1], dist_val} - {offset[ValW-1], offset};
    num_mag = dsub[ValW] ? NW'(-dsub) << FRAC_BITS : NW'(dsub) << FRAC_BITS;
    rem_sh  = {rem[ValW-1:0], quo[NW-1]};
    trial   = {1'b0, rem_sh} - {1'b0, den};
    diff    = trial[ValW:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num_mag;
      rem <= '0;
      den <= slope[ValW-1] ? -{slope[ValW-1], slope} : {1'b0, slope};
      neg <= dsub[ValW] ^ slope[ValW-1];
    end else if (busy) begin
      if (!trial[ValW+1]) begin
        rem <= diff;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg) begin
      quot = (quo > NW'(32'h7FFF_FFFF)) ? val_t'(32'h7FFF_FFFF) : val_t'(quo[ValW-1:0]);
    end else begin
      quot = (quo >= NW'(33'h0_8000_0000)) ? val_t'(32'h8000_0000)
                                           : val_t'(-quo[ValW-1:0]);
    end
  end

endmodule

/* rtl/core/rsit_back.sv */
module rsit_back
  import rsit_pkg::*;
#(
  parameter int unsigned NUM_PLANES = 7,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  plane_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  back_state_t state;
  back_state_t state_next;

  plane_t          cur;
  val_t            run_entry;
  val_t            run_exit;
  logic [IdxW-1:0] run_plane;
  logic [IdxW-1:0] plane_count;
  logic            missed;

  val_t            base_entry;
  val_t            base_exit;
  logic [IdxW-1:0] base_plane;
  logic [IdxW-1:0] base_count;
  logic            base_missed;
  logic            use_plane;

  logic div_start;
  logic dn_done;
  logic df_done;
  val_t tq_n;
  val_t tq_f;
  val_t tn;
  val_t tf;
  val_t ent_new;
  val_t ext_new;
  logic [IdxW-1:0] pl_new;

  logic out_busy;
  logic out_free;
  logic skip_last;
  logic fold_go;
  logic out_set;

  rsit_div #(.FRAC_BITS(FRAC_BITS)) u_div_near (
    .clk(clk), .rst(rst), .start(div_start), .dist_val(in_data.near_d),
    .offset(in_data.offset), .slope(in_data.slope), .done(dn_done), .quot(tq_n)
  );

  rsit_div #(.FRAC_BITS(FRAC_BITS)) u_div_far (
    .clk(clk), .rst(rst), .start(div_start), .dist_val(in_data.far_d),
    .offset(in_data.offset), .slope(in_data.slope), .done(df_done), .quot(tq_f)
  );

  always_comb begin
    base_entry  = in_data.first ? in_data.entry_start : run_entry;
    base_exit   = in_data.first ? in_data.exit_start  : run_exit;
    base_plane  = in_data.first ? in_data.plane_start : run_plane;
    base_count  = in_data.first ? '0 : plane_count;
    base_missed = in_data.first ? 1'b0 : missed;
    use_plane   = !base_missed && (32'(base_count) < NUM_PLANES) && (in_data.slope != '0);
  end

  // A waiting result only holds up a plane that has to write a new one.
  assign out_free  = !out_busy || out_ready;
  assign skip_last = in_data.last && !use_plane;
  assign in_ready  = (state == ST_IDLE) && (!skip_last || out_free);
  assign div_start = in_valid && in_ready && use_plane;
  assign fold_go   = (state == ST_FOLD) && (!cur.last || out_free);
  assign out_set   = (in_valid && in_ready && skip_last) || (fold_go && cur.last);

  always_comb begin
    tn = cur.slope[ValW-1] ? tq_f : tq_n;
    tf = cur.slope[ValW-1] ? tq_n : tq_f;
    ent_new = run_entry;
    pl_new  = run_plane;
    if (tn > run_entry) begin
      ent_new = tn;
      pl_new  = plane_count;
    end
    ext_new = (tf < run_exit) ? tf : run_exit;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (use_plane) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (dn_done && df_done) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (fold_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      run_entry   <= '0;
      run_exit    <= '0;
      run_plane   <= '0;
      plane_count <= '0;
      missed      <= 1'b0;
      out_busy    <= 1'b0;
    end else begin
      state    <= state_next;
      out_busy <= out_set || (out_busy && !out_ready);
      if (in_valid && in_ready) begin
        cur         <= in_data;
        run_entry   <= base_entry;
        run_exit    <= base_exit;
        run_plane   <= base_plane;
        missed      <= base_missed;
        if (!use_plane) begin
          plane_count <= (base_count == '1) ? base_count : base_count + 1'b1;
          if (in_data.last) begin
            out_data <= '{!base_missed, base_entry, base_exit, base_plane};
          end
        end else begin
          plane_count <= base_count;
        end
      end else if (fold_go) begin
        run_entry   <= ent_new;
        run_exit    <= ext_new;
        run_plane   <= pl_new;
        missed      <= ent_new > ext_new;
        plane_count <= (plane_count == '1) ? plane_count : plane_count + 1'b1;
        if (cur.last) begin
          out_data <= '{!(ent_new > ext_new), ent_new, ext_new, pl_new};
        end
      end
    end
  end

  assign out_valid = out_busy;

endmodule

/* rtl/core/ray_slab_interval_test_unit.sv */
// Kay-Kajiya slab test of one ray against a bounding volume, one plane per
// beat. Each input beat carries a slab (near and far distance) and the ray's
// precomputed offset and slope for that plane; the beat flagged first also
// loads the starting entry time, exit time and plane index. A result beat is
// sent after the beat flagged last. Values are signed Q16.16 by default. A
// plane that is used waits on the pair of one-bit-per-cycle dividers that
// form the entry and exit times in parallel; a plane that is skipped (zero
// slope, beyond NUM_PLANES, or after a miss) goes past the dividers. A
// two-beat queue lets the input side keep taking beats while the back end
// divides, and a registered result lets the back end go on while the result
// beat waits to be taken.
module ray_slab_interval_test_unit
  import rsit_pkg::*;
#(
  parameter int unsigned NUM_PLANES = 7,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slab_near, slab_far, ray_offset, ray_slope, entry_start, exit_start,
  // plane_start, zero fill
  input  logic [199:0] s_tdata,
  // first_plane, last_plane
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_time, exit_time, entry_plane, zero fill
  output logic [71:0]  m_tdata,
  // hit
  output logic         m_tuser
);

  plane_t  in_beat;
  plane_t  q_data;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  // Front: unpack the beat into a plane record.
  always_comb begin
    in_beat.near_d      = s_tdata[31:0];
    in_beat.far_d       = s_tdata[63:32];
    in_beat.offset      = s_tdata[95:64];
    in_beat.slope       = s_tdata[127:96];
    in_beat.entry_start = s_tdata[159:128];
    in_beat.exit_start  = s_tdata[191:160];
    in_beat.plane_start = s_tdata[195:192];
    in_beat.first       = s_tuser[0];
    in_beat.last        = s_tuser[1];
  end

  rsit_fifo #(.DEPTH(2)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(in_beat),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  rsit_back #(.NUM_PLANES(NUM_PLANES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
  );

  assign m_tdata = {4'b0, res.entry_plane, res.exit_time, res.entry_time};
  assign m_tuser = res.hit;

endmodule
